@@ design/uart_multidrop_master_transfer_core_assert.svh @@
// Assertion macros for the multidrop UART master transfer core.
// Plain text macros only; no package or module dependencies.
`ifndef UART_MULTIDROP_MASTER_TRANSFER_CORE_ASSERT_SVH
`define UART_MULTIDROP_MASTER_TRANSFER_CORE_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define UMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define UMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/umt_pkg.sv @@
// Shared types and constants for the multidrop UART master transfer core.
// No dependencies; imported by every module of the block except umt_ram.
`default_nettype none

package umt_pkg;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;

    localparam logic MODE_SEND = 1'b0;
    localparam logic MODE_RECV = 1'b1;

    localparam logic [7:0] RESET_BYTE = 8'hFF;
    localparam logic [7:0] NAK_BYTE   = 8'hFF;
    localparam logic [7:0] ACK_OK     = 8'h00;
    localparam logic [7:0] CODE_SEND  = 8'h01;
    localparam logic [7:0] CODE_RECV  = 8'h02;

    localparam int STAT_SEND   = 0;
    localparam int STAT_RECV   = 1;
    localparam int STAT_REJECT = 3;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ECHO,
        PH_STATUS,
        PH_ACK,
        PH_RECV
    } t_phase;

    typedef enum logic [2:0] {
        J_BYTE,
        J_RESET_CALL,
        J_BLOCK,
        J_DONE,
        J_DELIVER
    } t_job_kind;

    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] tx_byte;
        logic       ninth;
    } t_job;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RESET,
        B_SINGLE,
        B_DONE,
        B_STREAM,
        B_SUM
    } t_back_state;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_ninth_bit;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic [3:0] rx_index;
        logic       done_res;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

@@ design/umt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module umt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ design/umt_queue.sv @@
// Short job queue between the front end and the back end.
// Depends on umt_pkg for the job type and depth.
`default_nettype none

module umt_queue
    import umt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty,
    output logic      o_full
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_count;

    assign o_job   = r_q[r_rp];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/umt_front.sv @@
// Front end: accepts input transactions, tracks the call protocol phase,
// writes both block stores and queues output jobs. Depends on umt_pkg.
`default_nettype none

module umt_front
    import umt_pkg::*;
#(
    parameter int BLOCK_BYTES = 16,
    parameter int AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [1:0]             i_command,
    input  wire logic [3:0]             i_load_index,
    input  wire logic [7:0]             i_load_byte,
    input  wire logic                   i_operation,
    input  wire logic [7:0]             i_expected_address,
    input  wire logic [7:0]             i_rx_byte,
    input  wire logic [7:0]             i_call_address,
    input  wire logic                   i_drained,
    input  wire logic                   i_q_full,
    output logic                        o_push,
    output t_job                        o_job,
    output logic                        o_send_we,
    output logic [AW-1:0]               o_send_addr,
    output logic [7:0]                  o_send_data,
    output logic                        o_recv_we,
    output logic [AW-1:0]               o_recv_addr,
    output logic [7:0]                  o_recv_data,
    output logic [BLOCK_BYTES-1:0]      o_send_valid
);

    localparam int CW = $clog2(BLOCK_BYTES + 1);

    t_phase                  r_phase;
    t_phase                  n_phase;
    logic                    r_mode;
    logic [7:0]              r_echo;
    logic [CW-1:0]           r_count;
    logic [7:0]              r_sum;
    logic [BLOCK_BYTES-1:0]  r_send_valid;

    logic accept;
    logic need_drain;
    logic push_c;
    logic send_we_c;
    logic recv_we_c;
    t_job job_c;

    logic load_in_range;
    logic echo_match;
    logic reject;
    logic go_send;
    logic go_recv;
    logic gathering;
    logic sum_match;

    assign load_in_range = ({28'd0, i_load_index} < 32'(BLOCK_BYTES));
    assign echo_match    = (i_rx_byte == r_echo);
    assign reject        = i_rx_byte[STAT_REJECT];
    assign go_send       = !reject && (r_mode == MODE_SEND) && i_rx_byte[STAT_SEND];
    assign go_recv       = !reject && (r_mode == MODE_RECV) && i_rx_byte[STAT_RECV];
    assign gathering     = (r_count < CW'(BLOCK_BYTES));
    assign sum_match     = (i_rx_byte == r_sum);

    // classify the waiting transaction
    always_comb begin
        need_drain = 1'b0;
        push_c     = 1'b0;
        send_we_c  = 1'b0;
        recv_we_c  = 1'b0;
        job_c      = '{kind: J_BYTE, tx_byte: '0, ninth: 1'b0};
        unique case (i_command)
            CMD_LOAD: begin
                need_drain = 1'b1;
                send_we_c  = load_in_range;
            end
            CMD_START: begin
                push_c = 1'b1;
                job_c  = '{kind: J_BYTE, tx_byte: i_call_address, ninth: 1'b1};
            end
            CMD_RX: begin
                unique case (r_phase)
                    PH_ECHO: begin
                        push_c = 1'b1;
                        if (echo_match) begin
                            job_c = '{kind: J_BYTE, ninth: 1'b0,
                                      tx_byte: (r_mode == MODE_RECV) ? CODE_RECV : CODE_SEND};
                        end else begin
                            job_c = '{kind: J_RESET_CALL, tx_byte: i_call_address,
                                      ninth: 1'b1};
                        end
                    end
                    PH_STATUS: begin
                        if (reject) begin
                            push_c = 1'b1;
                            job_c  = '{kind: J_RESET_CALL, tx_byte: i_call_address,
                                       ninth: 1'b1};
                        end else if (go_send) begin
                            push_c = 1'b1;
                            job_c  = '{kind: J_BLOCK, tx_byte: '0, ninth: 1'b0};
                        end else if (!go_recv) begin
                            push_c = 1'b1;
                            job_c  = '{kind: J_BYTE, tx_byte: i_call_address, ninth: 1'b1};
                        end
                    end
                    PH_ACK: begin
                        push_c = 1'b1;
                        if (i_rx_byte == ACK_OK) begin
                            job_c = '{kind: J_DONE, tx_byte: '0, ninth: 1'b0};
                        end else begin
                            job_c = '{kind: J_BLOCK, tx_byte: '0, ninth: 1'b0};
                        end
                    end
                    PH_RECV: begin
                        if (gathering) begin
                            need_drain = 1'b1;
                            recv_we_c  = 1'b1;
                        end else if (sum_match) begin
                            push_c = 1'b1;
                            job_c  = '{kind: J_DELIVER, tx_byte: '0, ninth: 1'b0};
                        end else begin
                            push_c = 1'b1;
                            job_c  = '{kind: J_BYTE, tx_byte: NAK_BYTE, ninth: 1'b0};
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // store writes wait until the back end has finished reading
    assign o_ready = need_drain ? i_drained : (push_c ? !i_q_full : 1'b1);
    assign accept  = i_valid && o_ready;

    assign o_push      = accept && push_c;
    assign o_job       = job_c;
    assign o_send_we   = accept && send_we_c;
    assign o_send_addr = AW'(i_load_index);
    assign o_send_data = i_load_byte;
    assign o_recv_we   = accept && recv_we_c;
    assign o_recv_addr = r_count[AW-1:0];
    assign o_recv_data = i_rx_byte;
    assign o_send_valid = r_send_valid;

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (i_command)
                CMD_START: n_phase = PH_ECHO;
                CMD_RX: begin
                    unique case (r_phase)
                        PH_ECHO: begin
                            if (echo_match) begin
                                n_phase = PH_STATUS;
                            end
                        end
                        PH_STATUS: begin
                            if (reject) begin
                                n_phase = PH_ECHO;
                            end else if (go_send) begin
                                n_phase = PH_ACK;
                            end else if (go_recv) begin
                                n_phase = PH_RECV;
                            end else begin
                                n_phase = PH_ECHO;
                            end
                        end
                        PH_ACK: begin
                            if (i_rx_byte == ACK_OK) begin
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_RECV: begin
                            if (!gathering && sum_match) begin
                                n_phase = PH_IDLE;
                            end
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_mode       <= MODE_SEND;
            r_echo       <= '0;
            r_count      <= '0;
            r_sum        <= '0;
            r_send_valid <= '0;
        end else begin
            r_phase <= n_phase;
            if (o_send_we) begin
                r_send_valid[AW'(i_load_index)] <= 1'b1;
            end
            if (accept && (i_command == CMD_START)) begin
                r_mode <= i_operation;
                r_echo <= i_expected_address;
            end
            if (accept && (i_command == CMD_RX)) begin
                if ((r_phase == PH_STATUS) && go_recv) begin
                    r_count <= '0;
                    r_sum   <= '0;
                end else if (r_phase == PH_RECV) begin
                    if (gathering) begin
                        r_count <= r_count + CW'(1);
                        r_sum   <= r_sum + i_rx_byte;
                    end else begin
                        r_count <= '0;
                        r_sum   <= '0;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ design/umt_back.sv @@
// Back end: pops jobs and turns them into results, streaming block bytes
// from the stores one per cycle unless the output stalls. Depends on umt_pkg.
`default_nettype none

module umt_back
    import umt_pkg::*;
#(
    parameter int BLOCK_BYTES = 16,
    parameter int AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_empty,
    input  wire t_job                   i_job,
    output logic                        o_pop,
    output logic                        o_idle,
    input  wire logic [BLOCK_BYTES-1:0] i_send_valid,
    input  wire logic [7:0]             i_send_data,
    input  wire logic [7:0]             i_recv_data,
    output logic                        o_rd_en,
    output logic [AW-1:0]               o_rd_addr,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output t_result                     o_res
);

    localparam int CW = $clog2(BLOCK_BYTES + 1);

    t_back_state   r_state;
    t_back_state   n_state;
    t_job          r_job;
    logic [CW-1:0] r_rd_idx;
    logic [AW-1:0] r_emit_addr;
    logic          r_rd_pend;
    logic [7:0]    r_sum;
    logic          r_out_valid;
    t_result       r_res;

    logic       out_ok;
    logic       more;
    logic       advance;
    logic       final_byte;
    logic       emit;
    logic       rd_en;
    logic       pop;
    logic [7:0] send_byte;
    t_result    n_res;

    assign out_ok     = !r_out_valid || i_out_ready;
    assign more       = (r_rd_idx < CW'(BLOCK_BYTES));
    assign advance    = !r_rd_pend || out_ok;
    assign final_byte = (r_emit_addr == AW'(BLOCK_BYTES - 1));
    // entries never loaded read as zero
    assign send_byte  = i_send_valid[r_emit_addr] ? i_send_data : '0;

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            B_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_job.kind) inside
                        J_BYTE:             n_state = B_SINGLE;
                        J_RESET_CALL:       n_state = B_RESET;
                        J_DONE:             n_state = B_DONE;
                        J_BLOCK, J_DELIVER: n_state = B_STREAM;
                        default:            n_state = B_IDLE;
                    endcase
                end
            end
            B_RESET: begin
                if (out_ok) begin
                    n_state = B_SINGLE;
                end
            end
            B_SINGLE, B_DONE, B_SUM: begin
                if (out_ok) begin
                    n_state = B_IDLE;
                end
            end
            B_STREAM: begin
                if (r_rd_pend && out_ok && final_byte) begin
                    n_state = (r_job.kind == J_BLOCK) ? B_SUM : B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        pop   = 1'b0;
        emit  = 1'b0;
        rd_en = 1'b0;
        n_res = '0;
        unique case (r_state)
            B_IDLE: pop = !i_q_empty;
            B_RESET: begin
                emit               = out_ok;
                n_res.tx_valid     = 1'b1;
                n_res.tx_byte      = RESET_BYTE;
                n_res.tx_ninth_bit = 1'b1;
            end
            B_SINGLE: begin
                emit               = out_ok;
                n_res.tx_valid     = 1'b1;
                n_res.tx_byte      = r_job.tx_byte;
                n_res.tx_ninth_bit = r_job.ninth;
                n_res.last         = 1'b1;
            end
            B_DONE: begin
                emit           = out_ok;
                n_res.done_res = 1'b1;
                n_res.last     = 1'b1;
            end
            B_STREAM: begin
                rd_en = advance && more;
                emit  = r_rd_pend && out_ok;
                if (r_job.kind == J_BLOCK) begin
                    n_res.tx_valid = 1'b1;
                    n_res.tx_byte  = send_byte;
                end else begin
                    // first delivered byte also carries the 0x00 answer
                    n_res.tx_valid = (r_emit_addr == '0);
                    n_res.tx_byte  = ACK_OK;
                    n_res.rx_valid = 1'b1;
                    n_res.rx_data  = i_recv_data;
                    n_res.rx_index = 4'(r_emit_addr);
                    n_res.done_res = final_byte;
                    n_res.last     = final_byte;
                end
            end
            B_SUM: begin
                emit           = out_ok;
                n_res.tx_valid = 1'b1;
                n_res.tx_byte  = r_sum;
                n_res.last     = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res <= n_res;
        end
        if (pop) begin
            r_job <= i_job;
        end
        if (rd_en) begin
            r_emit_addr <= r_rd_idx[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_rd_idx    <= '0;
            r_rd_pend   <= 1'b0;
            r_sum       <= '0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (pop) begin
                r_rd_idx  <= '0;
                r_rd_pend <= 1'b0;
                r_sum     <= '0;
            end else if (r_state == B_STREAM) begin
                if (advance) begin
                    r_rd_pend <= more;
                end
                if (rd_en) begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                end
                if (emit && (r_job.kind == J_BLOCK)) begin
                    r_sum <= r_sum + send_byte;
                end
            end
        end
    end

    assign o_pop       = pop;
    assign o_idle      = (r_state == B_IDLE);
    assign o_rd_en     = rd_en;
    assign o_rd_addr   = r_rd_idx[AW-1:0];
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

@@ design/uart_multidrop_master_transfer_core.sv @@
// Master side of a nine-bit multidrop UART block transfer. Load
// transactions fill the transmit block; a start transaction calls the
// slave, and received-byte transactions drive the echo, status, acknowledge
// and receive phases. An input transaction that only queues output work
// is accepted while the queue (two jobs) is not full. Load transactions, and
// received data bytes while a block is being gathered, wait until the back
// end is idle and the queue is empty, since they write the block stores
// that the back end reads. With the back end free and the output not
// stalled, a single-byte job is popped and then registered as the result,
// and a reset call gives the reset byte before the call address; a block
// is popped, read from RAM, then gives one result per cycle: BLOCK_BYTES
// bytes and the sum in send mode, BLOCK_BYTES verified bytes in receive
// mode. Unloaded transmit entries read as zero through per-entry valid
// bits, so no clearing pass follows reset.
// Depends on umt_pkg, umt_ram, umt_queue, umt_front, umt_back.
`default_nettype none

`include "uart_multidrop_master_transfer_core_assert.svh"

module uart_multidrop_master_transfer_core
    import umt_pkg::*;
#(
    parameter int BLOCK_BYTES = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_command,
    input  wire logic [3:0] i_load_index,
    input  wire logic [7:0] i_load_byte,
    input  wire logic       i_operation,
    input  wire logic [7:0] i_expected_address,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_tx_valid,
    output logic [7:0]      o_tx_byte,
    output logic            o_tx_ninth_bit,
    output logic            o_rx_valid,
    output logic [7:0]      o_rx_data,
    output logic [3:0]      o_rx_index,
    output logic            o_done_res,
    output logic            o_last
);

    localparam int AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

    logic [7:0]             r_call_address;

    logic                   q_push;
    logic                   q_pop;
    logic                   q_empty;
    logic                   q_full;
    t_job                   push_job;
    t_job                   head_job;
    logic                   back_idle;
    logic                   drained;

    logic                   send_we;
    logic [AW-1:0]          send_wr_addr;
    logic [7:0]             send_wr_data;
    logic                   recv_we;
    logic [AW-1:0]          recv_wr_addr;
    logic [7:0]             recv_wr_data;
    logic                   store_we;
    logic [BLOCK_BYTES-1:0] send_valid;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [7:0]             send_rd_data;
    logic [7:0]             recv_rd_data;
    t_result                res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_call_address <= 8'd2;
        end else if (i_cfg_wr_en) begin
            r_call_address <= i_cfg_wr_data;
        end
    end

    assign drained  = back_idle && q_empty;
    assign store_we = send_we || recv_we;

    umt_front #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_in_valid),
        .o_ready            (o_in_ready),
        .i_command          (i_command),
        .i_load_index       (i_load_index),
        .i_load_byte        (i_load_byte),
        .i_operation        (i_operation),
        .i_expected_address (i_expected_address),
        .i_rx_byte          (i_rx_byte),
        .i_call_address     (r_call_address),
        .i_drained          (drained),
        .i_q_full           (q_full),
        .o_push             (q_push),
        .o_job              (push_job),
        .o_send_we          (send_we),
        .o_send_addr        (send_wr_addr),
        .o_send_data        (send_wr_data),
        .o_recv_we          (recv_we),
        .o_recv_addr        (recv_wr_addr),
        .o_recv_data        (recv_wr_data),
        .o_send_valid       (send_valid)
    );

    umt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    umt_ram #(
        .WIDTH (8),
        .DEPTH (BLOCK_BYTES)
    ) u_send_ram (
        .i_clk     (i_clk),
        .i_wr_en   (send_we),
        .i_wr_addr (send_wr_addr),
        .i_wr_data (send_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (send_rd_data)
    );

    umt_ram #(
        .WIDTH (8),
        .DEPTH (BLOCK_BYTES)
    ) u_recv_ram (
        .i_clk     (i_clk),
        .i_wr_en   (recv_we),
        .i_wr_addr (recv_wr_addr),
        .i_wr_data (recv_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (recv_rd_data)
    );

    umt_back #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_job        (head_job),
        .o_pop        (q_pop),
        .o_idle       (back_idle),
        .i_send_valid (send_valid),
        .i_send_data  (send_rd_data),
        .i_recv_data  (recv_rd_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_res        (res)
    );

    assign o_tx_valid     = res.tx_valid;
    assign o_tx_byte      = res.tx_byte;
    assign o_tx_ninth_bit = res.tx_ninth_bit;
    assign o_rx_valid     = res.rx_valid;
    assign o_rx_data      = res.rx_data;
    assign o_rx_index     = res.rx_index;
    assign o_done_res     = res.done_res;
    assign o_last         = res.last;

    `UMT_ASSERT_IMP(a_queue_no_overflow, i_clk, i_rst_n, q_push, !q_full, "job queue overflow")
    `UMT_ASSERT_IMP(a_queue_no_underflow, i_clk, i_rst_n, q_pop, !q_empty, "job queue underflow")
    `UMT_ASSERT_IMP(a_store_drained, i_clk, i_rst_n, store_we, drained, "store written while busy")
    `UMT_ASSERT_NXT(a_read_in_stream, i_clk, i_rst_n, rd_en, !back_idle, "read outside a stream")

endmodule

`default_nettype wire

@@ test/uart_multidrop_master_transfer_core_tb.sv @@
// Testbench for uart_multidrop_master_transfer_core: drives load, start and received-byte
// transactions, predicts every line word in order and checks it field by field.
// Depends on umt_pkg and the core RTL; needs no files or arguments at run time.
module uart_multidrop_master_transfer_core_tb;
    import umt_pkg::*;

    localparam int BLOCK_LEN = 16;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;
    logic i_in_valid;
    logic o_in_ready;
    logic [1:0] i_command;
    logic [3:0] i_load_index;
    logic [7:0] i_load_byte;
    logic i_operation;
    logic [7:0] i_expected_address;
    logic [7:0] i_rx_byte;
    logic o_out_valid;
    logic i_out_ready;
    logic o_tx_valid;
    logic [7:0] o_tx_byte;
    logic o_tx_ninth_bit;
    logic o_rx_valid;
    logic [7:0] o_rx_data;
    logic [3:0] o_rx_index;
    logic o_done_res;
    logic o_last;

    // predicted master state
    logic [7:0] call_addr;
    t_phase mst_phase;
    logic mst_mode;
    logic [7:0] mst_echo;
    logic [7:0] tx_block [BLOCK_LEN];
    logic [7:0] rx_block [BLOCK_LEN];
    logic [4:0] rx_count;
    logic [7:0] rx_sum;

    t_result due_words [$];

    bit gaps_on;
    int stall_hold = 0;
    int quiet_cycles = 0;
    int n_errors = 0;
    int n_items = 0;
    int n_checked = 0;
    int n_done = 0;

    uart_multidrop_master_transfer_core #(
        .BLOCK_BYTES(BLOCK_LEN)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_command(i_command),
        .i_load_index(i_load_index),
        .i_load_byte(i_load_byte),
        .i_operation(i_operation),
        .i_expected_address(i_expected_address),
        .i_rx_byte(i_rx_byte),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_tx_valid(o_tx_valid),
        .o_tx_byte(o_tx_byte),
        .o_tx_ninth_bit(o_tx_ninth_bit),
        .o_rx_valid(o_rx_valid),
        .o_rx_data(o_rx_data),
        .o_rx_index(o_rx_index),
        .o_done_res(o_done_res),
        .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic void queue_word(input logic txv, input logic [7:0] txb,
                                       input logic ninth, input logic rxv,
                                       input logic [7:0] rxd, input logic [3:0] rxi,
                                       input logic done);
        t_result w;
        w = '0;
        w.tx_valid = txv;
        w.tx_byte = txb;
        w.tx_ninth_bit = ninth;
        w.rx_valid = rxv;
        w.rx_data = rxd;
        w.rx_index = rxi;
        w.done_res = done;
        due_words.push_back(w);
    endfunction

    function automatic void queue_tx(input logic [7:0] b, input logic ninth);
        queue_word(1'b1, b, ninth, 1'b0, 8'h00, 4'h0, 1'b0);
    endfunction

    // whole transmit block followed by its 8-bit sum
    function automatic void queue_block();
        logic [7:0] sum;
        int i;
        sum = 8'h00;
        for (i = 0; i < BLOCK_LEN; i++) begin
            queue_tx(tx_block[i], 1'b0);
            sum = sum + tx_block[i];
        end
        queue_tx(sum, 1'b0);
    endfunction

    function automatic void advance_master(input logic [1:0] cmd, input logic [3:0] lidx,
                                           input logic [7:0] lbyte, input logic op,
                                           input logic [7:0] expa, input logic [7:0] rx);
        int base;
        int i;
        t_result w;
        base = due_words.size();
        case (cmd)
            CMD_LOAD: tx_block[lidx] = lbyte;
            CMD_START: begin
                mst_mode = op;
                mst_echo = expa;
                mst_phase = PH_ECHO;
                queue_tx(call_addr, 1'b1);
            end
            CMD_RX: begin
                case (mst_phase)
                    PH_ECHO: begin
                        if (rx != mst_echo) begin
                            queue_tx(RESET_BYTE, 1'b1);
                            queue_tx(call_addr, 1'b1);
                        end else begin
                            queue_tx(mst_mode == MODE_RECV ? CODE_RECV : CODE_SEND, 1'b0);
                            mst_phase = PH_STATUS;
                        end
                    end
                    PH_STATUS: begin
                        if (rx[STAT_REJECT]) begin
                            queue_tx(RESET_BYTE, 1'b1);
                            queue_tx(call_addr, 1'b1);
                            mst_phase = PH_ECHO;
                        end else if (mst_mode == MODE_SEND && rx[STAT_SEND]) begin
                            queue_block();
                            mst_phase = PH_ACK;
                        end else if (mst_mode == MODE_RECV && rx[STAT_RECV]) begin
                            rx_count = '0;
                            rx_sum = 8'h00;
                            mst_phase = PH_RECV;
                        end else begin
                            queue_tx(call_addr, 1'b1);
                            mst_phase = PH_ECHO;
                        end
                    end
                    PH_ACK: begin
                        if (rx == ACK_OK) begin
                            queue_word(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 1'b1);
                            mst_phase = PH_IDLE;
                        end else begin
                            queue_block();
                        end
                    end
                    PH_RECV: begin
                        if (rx_count < 5'(BLOCK_LEN)) begin
                            rx_block[rx_count[3:0]] = rx;
                            rx_sum = rx_sum + rx;
                            rx_count = rx_count + 5'd1;
                        end else if (rx == rx_sum) begin
                            // hand the verified block out, acknowledging on the first word
                            for (i = 0; i < BLOCK_LEN; i++)
                                queue_word(i == 0, ACK_OK, 1'b0, 1'b1, rx_block[i], 4'(i),
                                           i == BLOCK_LEN - 1);
                            rx_count = '0;
                            rx_sum = 8'h00;
                            mst_phase = PH_IDLE;
                        end else begin
                            queue_tx(NAK_BYTE, 1'b0);
                            rx_count = '0;
                            rx_sum = 8'h00;
                        end
                    end
                    default: mst_phase = PH_IDLE;
                endcase
            end
            default: ;
        endcase
        if (due_words.size() > base) begin
            w = due_words.pop_back();
            w.last = 1'b1;
            due_words.push_back(w);
        end
    endfunction

    // mostly the byte a well-behaved slave would answer, otherwise noise
    function automatic logic [7:0] pick_rx_byte();
        logic [7:0] b;
        int r;
        b = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        case (mst_phase)
            PH_ECHO: if (r < 80) b = mst_echo;
            PH_STATUS: begin
                if (r < 70) begin
                    b[STAT_REJECT] = 1'b0;
                    if (mst_mode == MODE_RECV)
                        b[STAT_RECV] = 1'b1;
                    else
                        b[STAT_SEND] = 1'b1;
                end else if (r < 85) begin
                    b[STAT_REJECT] = 1'b1;
                end
            end
            PH_ACK: if (r < 60) b = ACK_OK;
            PH_RECV: begin
                if (rx_count == 5'(BLOCK_LEN)) begin
                    if (r < 75)
                        b = rx_sum;
                    else
                        b = rx_sum ^ 8'($urandom_range(1, 255));
                end
            end
            default: ;
        endcase
        return b;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endfunction

    task automatic push_item(input logic [1:0] cmd, input logic [3:0] lidx,
                             input logic [7:0] lbyte, input logic op,
                             input logic [7:0] expa, input logic [7:0] rx);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command <= cmd;
        i_load_index <= lidx;
        i_load_byte <= lbyte;
        i_operation <= op;
        i_expected_address <= expa;
        i_rx_byte <= rx;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        advance_master(cmd, lidx, lbyte, op, expa, rx);
        n_items++;
    endtask

    task automatic put_load(input logic [3:0] idx, input logic [7:0] b);
        push_item(CMD_LOAD, idx, b, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic put_start(input logic op, input logic [7:0] addr);
        push_item(CMD_START, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), op, addr,
                  8'($urandom_range(0, 255)));
    endtask

    task automatic put_rx(input logic [7:0] b);
        push_item(CMD_RX, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), b);
    endtask

    task automatic release_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_call_address(input logic [7:0] v);
        release_input();
        wait_drained();
        i_cfg_wr_data <= v;
        i_cfg_wr_en <= 1'b1;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        call_addr = v;
    endtask

    task automatic test_idle_and_loads();
        put_load(4'd0, 8'hFF);
        put_load(4'd15, 8'h00);
        push_item(CMD_SPARE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
        // no transfer running: drop the byte
        put_rx(8'hA5);
    endtask

    task automatic test_send_block();
        put_start(MODE_SEND, 8'h00);
        put_rx(8'h33);
        put_rx(8'h00);
        put_rx(8'h08);
        put_rx(8'h00);
        put_rx(8'h04);
        put_rx(8'h00);
        put_rx(8'h01);
        put_rx(ACK_OK);
    endtask

    task automatic test_receive_block();
        int k;
        put_start(MODE_RECV, 8'hFF);
        put_rx(8'hFF);
        put_rx(8'h02);
        for (k = 0; k < BLOCK_LEN; k++)
            put_rx(k == 0 ? 8'h00 : (k == 1 ? 8'hFF : 8'($urandom_range(0, 255))));
        put_rx(rx_sum);
    endtask

    task automatic test_output_stall();
        // hold the sink off so the block backs up into the input
        stall_hold = 300;
        put_start(MODE_SEND, 8'h3C);
        put_rx(8'h3C);
        put_rx(8'h01);
        put_rx(8'h80);
        put_rx(ACK_OK);
        release_input();
        wait_drained();
    endtask

    task automatic test_random_traffic(input int quota);
        int counted;
        int r;
        counted = 0;
        while (counted < quota) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                push_item(CMD_SPARE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            end else if (r < 11) begin
                put_load(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
                counted++;
            end else if (mst_phase == PH_IDLE && r < 20) begin
                put_rx(8'($urandom_range(0, 255)));
            end else if (mst_phase == PH_IDLE || r < 14) begin
                put_start(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                counted++;
            end else begin
                put_rx(pick_rx_byte());
                counted++;
            end
        end
    endtask

    initial begin : line_sink
        int pause;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (stall_hold > 0) begin
                pause = stall_hold;
                stall_hold = 0;
            end else begin
                pause = gaps_on ? $urandom_range(0, 3) : 0;
            end
            if (pause > 0) begin
                i_out_ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin : line_check
        t_result want;
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (o_out_valid && i_out_ready) begin
                if (due_words.size() == 0) begin
                    $error("result with nothing expected: tx 0x%0h rx 0x%0h",
                           o_tx_byte, o_rx_data);
                    n_errors++;
                end else begin
                    want = due_words.pop_front();
                    check_field("tx_valid", 8'(want.tx_valid), 8'(o_tx_valid));
                    check_field("tx_byte", want.tx_byte, o_tx_byte);
                    check_field("tx_ninth_bit", 8'(want.tx_ninth_bit), 8'(o_tx_ninth_bit));
                    check_field("rx_valid", 8'(want.rx_valid), 8'(o_rx_valid));
                    check_field("rx_data", want.rx_data, o_rx_data);
                    check_field("rx_index", 8'(want.rx_index), 8'(o_rx_index));
                    check_field("done_res", 8'(want.done_res), 8'(o_done_res));
                    check_field("last", 8'(want.last), 8'(o_last));
                    n_checked++;
                    if (want.done_res)
                        n_done++;
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("no transaction for %0d cycles, %0d results outstanding",
                         quiet_cycles, due_words.size());
                $display("uart_multidrop_master_transfer_core verification failed");
                $finish;
            end
        end
    end

    initial begin : run_tests
        int k;
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= 8'h00;
        i_in_valid <= 1'b0;
        i_command <= CMD_LOAD;
        i_load_index <= 4'h0;
        i_load_byte <= 8'h00;
        i_operation <= MODE_SEND;
        i_expected_address <= 8'h00;
        i_rx_byte <= 8'h00;
        call_addr = 8'd2;
        mst_phase = PH_IDLE;
        mst_mode = MODE_SEND;
        mst_echo = 8'h00;
        rx_count = '0;
        rx_sum = 8'h00;
        for (k = 0; k < BLOCK_LEN; k++) begin
            tx_block[k] = 8'h00;
            rx_block[k] = 8'h00;
        end
        gaps_on = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_and_loads();
        test_send_block();
        test_receive_block();
        test_output_stall();

        write_call_address(8'h00);
        test_random_traffic(100);
        write_call_address(8'hFF);
        gaps_on = 1'b0;
        test_random_traffic(100);
        write_call_address(8'($urandom_range(1, 254)));
        gaps_on = 1'b1;
        test_random_traffic(100);

        release_input();
        wait_drained();
        $display("covered %0d input transactions, %0d checked results, %0d finished transfers",
                 n_items, n_checked, n_done);
        $display("send and receive exchanges with retries, rejects, long output stall, "
                 , "call address reset value, 0x00, 0xff and random");
        if (n_errors == 0) begin
            $display("uart_multidrop_master_transfer_core verification clean");
        end else begin
            $display("uart_multidrop_master_transfer_core verification failed");
        end
        $finish;
    end

endmodule
